// ===== hdl/rmdr_pkg.sv =====
// Package: shared widths, FSM state type and interface structs for the rational mul/div block.
`timescale 1ns / 1ps
package rmdr_pkg;

  // Fixed operand and result widths.
  localparam int unsigned NumW = 16;
  localparam int unsigned DenW = 15;
  localparam int unsigned MagW = 31;
  localparam int unsigned ResNumW = 32;
  localparam int unsigned ResDenW = 31;
  localparam int unsigned CntW = $clog2(MagW);

  typedef enum logic {
    CMD_MUL = 1'b0,
    CMD_DIV = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_GCD,
    ST_DIVT,
    ST_DIVB
  } state_e;

  // Cross-product front end results.
  typedef struct packed {
    logic [MagW-1:0] top_mag;
    logic [MagW-1:0] bot_mag;
    logic            neg;
    logic            div_by_zero;
    logic            top_zero;
  } prod_t;

  // Shared subtractor results.
  typedef struct packed {
    logic [MagW-1:0] diff;
    logic            borrow;
    logic            zero;
  } sub_res_t;

endpackage

// ===== hdl/rmdr_prod.sv =====
// Cross-product front end: operand magnitudes, products, sign and special cases.
`timescale 1ns / 1ps
module rmdr_prod (
  input  logic                          cmd_i,
  input  logic signed [rmdr_pkg::NumW-1:0] a_num_i,
  input  logic        [rmdr_pkg::DenW-1:0] a_den_i,
  input  logic signed [rmdr_pkg::NumW-1:0] b_num_i,
  input  logic        [rmdr_pkg::DenW-1:0] b_den_i,
  output rmdr_pkg::prod_t               prod_o
);
  import rmdr_pkg::*;

  logic [NumW-1:0]   a_mag;
  logic [NumW-1:0]   b_mag;
  logic [NumW-1:0]   top_op;
  logic [NumW-1:0]   bot_op;
  logic [2*NumW-1:0] top_full;
  logic [2*NumW-1:0] bot_full;

  // Magnitude of the most negative value still fits unsigned.
  assign a_mag = a_num_i[NumW-1] ? (~a_num_i + 1'b1) : a_num_i;
  assign b_mag = b_num_i[NumW-1] ? (~b_num_i + 1'b1) : b_num_i;

  // Divide swaps the second fraction.
  assign top_op = (cmd_e'(cmd_i) == CMD_DIV) ? {1'b0, b_den_i} : b_mag;
  assign bot_op = (cmd_e'(cmd_i) == CMD_DIV) ? b_mag : {1'b0, b_den_i};

  assign top_full = a_mag * top_op;
  assign bot_full = {1'b0, a_den_i} * bot_op;

  assign prod_o.top_mag     = top_full[MagW-1:0];
  assign prod_o.bot_mag     = bot_full[MagW-1:0];
  assign prod_o.neg         = a_num_i[NumW-1] ^ b_num_i[NumW-1];
  assign prod_o.div_by_zero = (bot_full == '0);
  assign prod_o.top_zero    = (top_full == '0);

endmodule

// ===== hdl/rmdr_sub.sv =====
// Shared subtract/compare unit used by the GCD steps and the restoring divider.
`timescale 1ns / 1ps
module rmdr_sub (
  input  logic [rmdr_pkg::MagW-1:0] a_i,
  input  logic [rmdr_pkg::MagW-1:0] b_i,
  output rmdr_pkg::sub_res_t        res_o
);
  import rmdr_pkg::*;

  logic [MagW:0] full;

  assign full = {1'b0, a_i} - {1'b0, b_i};

  assign res_o.diff   = full[MagW-1:0];
  assign res_o.borrow = full[MagW];
  assign res_o.zero   = (full == '0);

endmodule

// ===== hdl/rational_mul_div_reduce.sv =====
// Top level: sequencer for rational multiply/divide with GCD reduction.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive cmd_i and the four operand fields with start_i high.
//   The beat is taken at a rising edge where start_i is high and busy_o is low.
//   Result channel: done_o is high for exactly one cycle with res_num_o,
//   res_den_o and div_by_zero_o valid. The receiver cannot stall; it must
//   take the beat in that cycle.
// Operation
//   Zero numerator or zero denominator product: result in the cycle after
//   accept, busy_o never rises. Otherwise the products are reduced by a
//   binary GCD (one shift or one subtract-or-swap per cycle) followed by two
//   restoring divisions by the GCD. Every subtract and compare goes through
//   one shared 31-bit subtractor. busy_o drops as done_o rises, so a new
//   command can be taken at the edge that ends the result beat.
// Reset
//   rst_ni low clears the sequencer to idle and drops done_o; no clearing
//   pass is needed, the block is ready right after reset.
module rational_mul_div_reduce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cmd_i,
  input  logic signed [rmdr_pkg::NumW-1:0]    a_num_i,
  input  logic        [rmdr_pkg::DenW-1:0]    a_den_i,
  input  logic signed [rmdr_pkg::NumW-1:0]    b_num_i,
  input  logic        [rmdr_pkg::DenW-1:0]    b_den_i,
  output logic                                done_o,
  output logic signed [rmdr_pkg::ResNumW-1:0] res_num_o,
  output logic        [rmdr_pkg::ResDenW-1:0] res_den_o,
  output logic                                div_by_zero_o
);
  import rmdr_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(MagW - 1);

  state_e state_q, state_d;

  prod_t    prod;
  sub_res_t sub;
  logic [MagW-1:0] sub_a, sub_b;

  // Working registers.
  logic [MagW-1:0] x_q, x_d, y_q, y_d;
  logic [CntW-1:0] k_q, k_d;
  logic [MagW-1:0] g_q, g_d;
  logic [MagW-1:0] top_q, top_d, bot_q, bot_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] rem_q, rem_d, qr_q, qr_d;
  logic [MagW-1:0] tq_q, tq_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Result registers.
  logic                      done_q, done_d;
  logic [ResNumW-1:0]        res_num_q, res_num_d;
  logic [ResDenW-1:0]        res_den_q, res_den_d;
  logic                      dbz_q, dbz_d;

  logic            accept;
  logic            special;
  logic [MagW-1:0] trial;
  logic            qbit;
  logic [MagW-1:0] qnext;

  rmdr_prod u_prod (
    .cmd_i   (cmd_i),
    .a_num_i (a_num_i),
    .a_den_i (a_den_i),
    .b_num_i (b_num_i),
    .b_den_i (b_den_i),
    .prod_o  (prod)
  );

  rmdr_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub)
  );

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign special = prod.div_by_zero || prod.top_zero;

  // Divider step: shift the next dividend bit into the partial remainder.
  assign trial = {rem_q[MagW-2:0], qr_q[MagW-1]};
  assign qbit  = !sub.borrow;
  assign qnext = {qr_q[MagW-2:0], qbit};

  // Route the shared subtractor.
  always_comb begin
    if (state_q == ST_DIVT || state_q == ST_DIVB) begin
      sub_a = trial;
      sub_b = g_q;
    end else begin
      sub_a = x_q;
      sub_b = y_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !special) state_d = ST_TWOS;
      end
      ST_TWOS: begin
        if (x_q[0] || y_q[0]) state_d = ST_GCD;
      end
      ST_GCD: begin
        if (x_q[0] && y_q[0] && sub.zero) state_d = ST_DIVT;
      end
      ST_DIVT: begin
        if (cnt_q == LastCnt) state_d = ST_DIVB;
      end
      ST_DIVB: begin
        if (cnt_q == LastCnt) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result updates.
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    k_d       = k_q;
    g_d       = g_q;
    top_d     = top_q;
    bot_d     = bot_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    qr_d      = qr_q;
    tq_d      = tq_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    dbz_d     = dbz_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (special) begin
            // Answer 0/1 at once; flag a zero denominator product.
            done_d    = 1'b1;
            res_num_d = '0;
            res_den_d = ResDenW'(1);
            dbz_d     = prod.div_by_zero;
          end else begin
            x_d   = prod.top_mag;
            y_d   = prod.bot_mag;
            top_d = prod.top_mag;
            bot_d = prod.bot_mag;
            neg_d = prod.neg;
            k_d   = '0;
          end
        end
      end
      ST_TWOS: begin
        // Strip common factors of two, count them.
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      ST_GCD: begin
        priority if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (sub.zero) begin
          // Equal odd values: restore the power of two and start dividing.
          g_d   = x_q << k_q;
          rem_d = '0;
          qr_d  = top_q;
          cnt_d = '0;
        end else if (sub.borrow) begin
          // Swap so the larger value sits in x.
          x_d = y_q;
          y_d = x_q;
        end else begin
          x_d = sub.diff;
        end
      end
      ST_DIVT, ST_DIVB: begin
        rem_d = qbit ? sub.diff : trial;
        qr_d  = qnext;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          rem_d = '0;
          cnt_d = '0;
          if (state_q == ST_DIVT) begin
            tq_d = qnext;
            qr_d = bot_q;
          end else begin
            done_d    = 1'b1;
            res_num_d = neg_q ? (~{1'b0, tq_q} + 1'b1) : {1'b0, tq_q};
            res_den_d = qnext;
            dbz_d     = 1'b0;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    k_q       <= k_d;
    g_q       <= g_d;
    top_q     <= top_d;
    bot_q     <= bot_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    qr_q      <= qr_d;
    tq_q      <= tq_d;
    cnt_q     <= cnt_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    dbz_q     <= dbz_d;
  end

  assign done_o        = done_q;
  assign res_num_o     = res_num_q;
  assign res_den_o     = res_den_q;
  assign div_by_zero_o = dbz_q;

  // A result beat only leaves an idle sequencer.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  // Flagged results always read 0/1.
  a_dbz_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_by_zero_o) |-> (res_num_o == '0 && res_den_o == ResDenW'(1)))
    else $error("div_by_zero result is not 0/1");

  // The GCD loop never sees a zero operand.
  a_gcd_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD || state_q == ST_TWOS) |-> (x_q != '0 && y_q != '0))
    else $error("zero operand inside GCD loop");

  // A nontrivial command always starts the reduction.
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !special) |=> busy_o)
    else $error("accepted command did not start the sequencer");

  // The divisor is nonzero while dividing.
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVT || state_q == ST_DIVB) |-> (g_q != '0))
    else $error("zero divisor in reduction");

endmodule
